// ----- hw/rtl/thac_pkg.sv -----
package thac_pkg;

  // field widths
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned RAW_W    = 32;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned VIEW_W   = 8;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned TOP_W    = 17;
  localparam int unsigned SHR_W    = 4;
  localparam int unsigned FILL_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // reset values and limits
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 24'd320000;
  localparam logic [VIEW_W-1:0]   VIEW_RST     = 8'd64;
  localparam logic [TOP_W-1:0]    TOP_MIN      = 17'd64;
  localparam logic [TOP_W-1:0]    TOP_MAX      = 17'd65536;
  localparam logic [SHR_W-1:0]    SHRINK_AFTER = 4'd10;
  localparam logic [SMP_W-1:0]    SMP_MAX      = 16'hFFFF;
  localparam logic [TOP_W-1:0]    RATE_SPAN    = 17'd8;
  localparam int unsigned         KIB_SHIFT    = 10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_PERIOD = 1'b0,
    REG_VIEW_WIDTH    = 1'b1
  } cfg_reg_e;

  // operations of the shared scan unit
  typedef enum logic [1:0] {
    SCAN_HOLD  = 2'd0,
    SCAN_CLEAR = 2'd1,
    SCAN_PEAK  = 2'd2,
    SCAN_RANGE = 2'd3
  } scan_op_e;

  // one history row
  typedef struct packed {
    logic [SMP_W-1:0] level;
    logic [SMP_W-1:0] threshold;
    logic [SMP_W-1:0] rate;
  } hist_entry_t;

  // input beat
  typedef struct packed {
    logic [TIME_W-1:0]       time_us;
    logic                    streaming;
    logic [FREQ_W-1:0]       tuned_freq;
    logic signed [RAW_W-1:0] level_sample;
    logic signed [RAW_W-1:0] trigger_level;
    logic [RAW_W-1:0]        byte_rate;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic              sampled;
    logic [FILL_W-1:0] fill_count;
    logic [TOP_W-1:0]  level_top;
    logic [SMP_W-1:0]  rate_low;
    logic [SMP_W-1:0]  rate_top;
    logic [SMP_W-1:0]  latest_level;
    logic [SMP_W-1:0]  latest_threshold;
    logic [SMP_W-1:0]  latest_rate;
  } out_beat_t;

endpackage

// ----- hw/rtl/thac_hist.sv -----
module thac_hist #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  thac_pkg::hist_entry_t      wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output thac_pkg::hist_entry_t      rdata_o
);
  import thac_pkg::*;

  hist_entry_t mem_q [DEPTH];
  hist_entry_t rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/thac_scan.sv -----
module thac_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  thac_pkg::scan_op_e              op_i,
  input  thac_pkg::hist_entry_t           data_i,
  output logic [thac_pkg::SMP_W-1:0]      peak_o,
  output logic [thac_pkg::SMP_W-1:0]      lo_o,
  output logic [thac_pkg::SMP_W-1:0]      hi_o
);
  import thac_pkg::*;

  logic [SMP_W-1:0] peak_q, peak_d;
  logic [SMP_W-1:0] lo_q, lo_d;
  logic [SMP_W-1:0] hi_q, hi_d;
  logic [SMP_W-1:0] row_max;

  // larger of level and threshold in the row
  assign row_max = (data_i.threshold > data_i.level) ? data_i.threshold : data_i.level;

  // clear, or accumulate the peak or the min/max of the rate column
  always_comb begin
    peak_d = peak_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    case (op_i)
      SCAN_CLEAR: begin
        peak_d = '0;
        lo_d   = SMP_MAX;
        hi_d   = '0;
      end
      SCAN_PEAK: begin
        if (row_max > peak_q) peak_d = row_max;
      end
      SCAN_RANGE: begin
        if (data_i.rate < lo_q) lo_d = data_i.rate;
        if (data_i.rate > hi_q) hi_d = data_i.rate;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      lo_q   <= SMP_MAX;
      hi_q   <= '0;
    end else begin
      peak_q <= peak_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
    end
  end

  assign peak_o = peak_q;
  assign lo_o   = lo_q;
  assign hi_o   = hi_q;

endmodule

// ----- hw/rtl/trend_history_autoscale_core.sv -----
// channel | dir | handshake              | payload
// --------+-----+------------------------+----------------------------------
// in      | in  | in_valid_i / in_stall_o | in_i  (thac_pkg::in_beat_t)
// out     | out | out_valid_o / out_stall_i | out_o (thac_pkg::out_beat_t)
// cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// Stored samples number up to HISTORY_DEPTH; both history walks go through
// the single read port of the history memory, one row a cycle.
// rst_ni clears control state and the scale; history rows need no clearing.
// in_stall_o is high from acceptance until the result is loaded; the result
// register holds under out_stall_i while the next beat is already accepted.
module trend_history_autoscale_core #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  thac_pkg::in_beat_t                   in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output thac_pkg::out_beat_t                  out_o,
  input  logic                                 cfg_we_i,
  input  logic [thac_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [thac_pkg::PERIOD_W-1:0]        cfg_wdata_i
);
  import thac_pkg::*;

  localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned MW    = (CNT_W > VIEW_W) ? CNT_W : VIEW_W;
  localparam int unsigned GAP_W = TIME_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_GAP    = 11'b000_0000_0010,
    S_DECIDE = 11'b000_0000_0100,
    S_PEAK   = 11'b000_0000_1000,
    S_ADJ    = 11'b000_0001_0000,
    S_WANT   = 11'b000_0010_0000,
    S_SCALE  = 11'b000_0100_0000,
    S_RANGE  = 11'b000_1000_0000,
    S_PAD    = 11'b001_0000_0000,
    S_BASE   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

  // control state
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     newest_q, newest_d;
  logic [TIME_W-1:0]    last_time_q, last_time_d;
  logic [FREQ_W-1:0]    last_freq_q, last_freq_d;
  logic [TOP_W-1:0]     top_q, top_d;
  logic [SHR_W-1:0]     shrink_q, shrink_d;
  logic [PERIOD_W-1:0]  period_q;
  logic [VIEW_W-1:0]    view_q;
  logic                 out_valid_q, out_valid_d;
  logic [CNT_W-1:0]     left_q, left_d;
  logic                 dv_q, dv_d;

  // datapath registers
  in_beat_t                 in_q, in_d;
  logic signed [GAP_W-1:0]  gap_q, gap_d;
  logic [IDX_W-1:0]         addr_q, addr_d;
  logic                     sampled_q, sampled_d;
  logic [TOP_W-1:0]         want_q, want_d;
  logic [TOP_W-1:0]         adj_q, adj_d;
  hist_entry_t              latest_q, latest_d;
  logic                     cond_q, cond_d;
  logic [SMP_W-1:0]         pad_q, pad_d;
  logic [SMP_W-1:0]         base_q, base_d;
  out_beat_t                out_q, out_d;

  // decision and write-side signals
  logic                 clear_w, take_w, gap_gt2p, gap_ltp;
  logic [CNT_W-1:0]     cnt_eff, cnt_new;
  logic [IDX_W-1:0]     new_slot;
  logic [MW-1:0]        cnt_new_w, view_w;
  hist_entry_t          wentry;
  logic                 mem_we;
  hist_entry_t          rdata;
  scan_op_e             scan_op;
  logic [SMP_W-1:0]     peak, lo, hi;
  logic [TOP_W-1:0]     span_sum, rtop_w;
  logic [SMP_W-1:0]     rtop_sat;

  // clamp a signed raw value to 0..65535
  function automatic logic [SMP_W-1:0] clamp_raw(input logic [RAW_W-1:0] v);
    logic [SMP_W-1:0] r;
    if (v[RAW_W-1]) r = '0;
    else if (|v[RAW_W-2:SMP_W]) r = SMP_MAX;
    else r = v[SMP_W-1:0];
    return r;
  endfunction

  // history row storage
  thac_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (new_slot),
    .wdata_i (wentry),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // shared compare unit for peak and rate range
  thac_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (scan_op),
    .data_i (rdata),
    .peak_o (peak),
    .lo_o   (lo),
    .hi_o   (hi)
  );

  // row written for the current beat
  always_comb begin
    wentry.level     = clamp_raw(in_q.level_sample);
    wentry.threshold = clamp_raw(in_q.trigger_level);
    if (|in_q.byte_rate[RAW_W-1:SMP_W+KIB_SHIFT]) wentry.rate = SMP_MAX;
    else wentry.rate = in_q.byte_rate[SMP_W+KIB_SHIFT-1:KIB_SHIFT];
  end

  // gap checks against one and two sample periods
  assign gap_gt2p = gap_q > $signed({{(GAP_W-PERIOD_W-1){1'b0}}, period_q, 1'b0});
  assign gap_ltp  = gap_q < $signed({{(GAP_W-PERIOD_W){1'b0}}, period_q});

  assign clear_w = !in_q.streaming || (in_q.tuned_freq != last_freq_q) ||
                   ((count_q != '0) && gap_gt2p);
  assign cnt_eff = clear_w ? '0 : count_q;
  assign take_w  = in_q.streaming && ((cnt_eff == '0) || !gap_ltp);
  assign new_slot = (cnt_eff == '0) ? '0 :
                    (newest_q == LAST_IDX) ? '0 : newest_q + 1'b1;
  assign cnt_new  = (cnt_eff == FULL_CNT) ? cnt_eff : cnt_eff + 1'b1;
  assign cnt_new_w = MW'(cnt_new);
  assign view_w    = MW'(view_q);

  // rate chart top: max of high and baseline plus span, saturated
  assign span_sum = {1'b0, base_q} + RATE_SPAN;
  assign rtop_w   = (span_sum > {1'b0, hi}) ? span_sum : {1'b0, hi};
  assign rtop_sat = rtop_w[TOP_W-1] ? SMP_MAX : rtop_w[SMP_W-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    newest_d    = newest_q;
    last_time_d = last_time_q;
    last_freq_d = last_freq_q;
    top_d       = top_q;
    shrink_d    = shrink_q;
    out_valid_d = out_valid_q;
    left_d      = left_q;
    dv_d        = dv_q;
    in_d        = in_q;
    gap_d       = gap_q;
    addr_d      = addr_q;
    sampled_d   = sampled_q;
    want_d      = want_q;
    adj_d       = adj_q;
    latest_d    = latest_q;
    cond_d      = cond_q;
    pad_d       = pad_q;
    base_d      = base_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    scan_op     = SCAN_HOLD;

    // result beat taken
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_i;
          state_d = S_GAP;
        end
      end
      S_GAP: begin
        gap_d   = $signed({1'b0, in_q.time_us}) - $signed({1'b0, last_time_q});
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        scan_op     = SCAN_CLEAR;
        last_freq_d = in_q.tuned_freq;
        dv_d        = 1'b0;
        if (clear_w) begin
          count_d     = '0;
          newest_d    = '0;
          last_time_d = '0;
          top_d       = TOP_MIN;
          shrink_d    = '0;
        end
        if (take_w) begin
          mem_we      = 1'b1;
          last_time_d = in_q.time_us;
          newest_d    = new_slot;
          count_d     = cnt_new;
          latest_d    = wentry;
          sampled_d   = 1'b1;
          addr_d      = new_slot;
          left_d      = (view_w < cnt_new_w) ? CNT_W'(view_w) : cnt_new;
          state_d     = S_PEAK;
        end else begin
          sampled_d = 1'b0;
          addr_d    = '0;
          left_d    = cnt_eff;
          state_d   = S_RANGE;
        end
      end
      S_PEAK: begin
        // newest first, walking backward with wrap
        if (dv_q) scan_op = SCAN_PEAK;
        if (left_q != '0) begin
          addr_d = (addr_q == '0) ? LAST_IDX : addr_q - 1'b1;
          left_d = left_q - 1'b1;
          dv_d   = 1'b1;
        end else begin
          dv_d = 1'b0;
          if (!dv_q) state_d = S_ADJ;
        end
      end
      S_ADJ: begin
        adj_d   = {1'b0, peak} + TOP_W'(peak >> 2);
        want_d  = TOP_MIN;
        state_d = S_WANT;
      end
      S_WANT: begin
        // one doubling per cycle until the adjusted peak or the cap is reached
        if ((want_q < adj_q) && (want_q != TOP_MAX)) want_d = want_q << 1;
        else state_d = S_SCALE;
      end
      S_SCALE: begin
        if (want_q > top_q) begin
          top_d    = want_q;
          shrink_d = '0;
        end else if (want_q < top_q) begin
          if (shrink_q + 1'b1 >= SHRINK_AFTER) begin
            top_d    = want_q;
            shrink_d = '0;
          end else begin
            shrink_d = shrink_q + 1'b1;
          end
        end else begin
          shrink_d = '0;
        end
        addr_d  = '0;
        left_d  = count_q;
        dv_d    = 1'b0;
        state_d = S_RANGE;
      end
      S_RANGE: begin
        // slot 0 upward over all stored rows
        if (dv_q) scan_op = SCAN_RANGE;
        if (left_q != '0) begin
          addr_d = addr_q + 1'b1;
          left_d = left_q - 1'b1;
          dv_d   = 1'b1;
        end else begin
          dv_d = 1'b0;
          if (!dv_q) state_d = S_PAD;
        end
      end
      S_PAD: begin
        cond_d  = (hi != '0) && (lo > (hi >> 2));
        pad_d   = ((hi - lo) >> 2) + 1'b1;
        state_d = S_BASE;
      end
      S_BASE: begin
        base_d  = (cond_q && (lo >= pad_q)) ? lo - pad_q : '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.sampled          = sampled_q;
          out_d.fill_count       = FILL_W'(count_q);
          out_d.level_top        = top_q;
          out_d.rate_low         = base_q;
          out_d.rate_top         = rtop_sat;
          out_d.latest_level     = (count_q != '0) ? latest_q.level : '0;
          out_d.latest_threshold = (count_q != '0) ? latest_q.threshold : '0;
          out_d.latest_rate      = (count_q != '0) ? latest_q.rate : '0;
          out_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      newest_q    <= '0;
      last_time_q <= '0;
      last_freq_q <= '0;
      top_q       <= TOP_MIN;
      shrink_q    <= '0;
      period_q    <= PERIOD_RST;
      view_q      <= VIEW_RST;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      dv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      newest_q    <= newest_d;
      last_time_q <= last_time_d;
      last_freq_q <= last_freq_d;
      top_q       <= top_d;
      shrink_q    <= shrink_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      dv_q        <= dv_d;
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SAMPLE_PERIOD: period_q <= cfg_wdata_i;
          REG_VIEW_WIDTH:    view_q   <= cfg_wdata_i[VIEW_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    gap_q     <= gap_d;
    addr_q    <= addr_d;
    sampled_q <= sampled_d;
    want_q    <= want_d;
    adj_q     <= adj_d;
    latest_q  <= latest_d;
    cond_q    <= cond_d;
    pad_q     <= pad_d;
    base_q    <= base_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("sample count beyond history depth");

  a_newest_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (CNT_W'(newest_q) < count_q))
    else $error("newest slot outside filled rows");

  a_top_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(top_q) && (top_q >= TOP_MIN))
    else $error("scale top not a power of two in range");

  a_shrink_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shrink_q < SHRINK_AFTER)
    else $error("shrink count reached limit without reset");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_GAP))
    else $error("accepted beat did not start the sequence");
`endif

endmodule

// ----- verif/trend_history_autoscale_core_tb.sv -----
`timescale 1ns / 100ps

module trend_history_autoscale_core_tb;
  import thac_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned SETTLE_CYCLES = 400;

  // block ports, all inputs known from time zero
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_beat_t             in_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_beat_t            out_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_SAMPLE_PERIOD;
  logic [PERIOD_W-1:0]  cfg_wdata_i = '0;

  trend_history_autoscale_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // chart state mirrored by the predictor
  logic [SMP_W-1:0]  hist_level  [DEPTH];
  logic [SMP_W-1:0]  hist_thresh [DEPTH];
  logic [SMP_W-1:0]  hist_rate   [DEPTH];
  int unsigned       newest_idx;
  bit                hist_live;
  int unsigned       fill;
  logic [TIME_W-1:0] last_store_us;
  logic [FREQ_W-1:0] prev_freq;
  int unsigned       top_now;
  int unsigned       shrink_run;
  int unsigned       period_us;
  int unsigned       view_n;

  // expected readouts and error tally
  out_beat_t   pending_readouts[$];
  out_beat_t   want_readout;
  int unsigned mismatch_cnt = 0;
  int unsigned readout_no = 0;

  // traffic generator state
  logic [TIME_W-1:0] now_us;
  logic [FREQ_W-1:0] cur_freq;
  int unsigned       seq_left;
  int unsigned       level_exp;
  int unsigned       rate_center;
  int unsigned       rate_spread;
  bit                idle_on = 1'b1;
  int unsigned       stall_left = 0;
  int unsigned       free_left = 0;

  function automatic logic [SMP_W-1:0] clamp_raw(logic signed [RAW_W-1:0] raw);
    if (raw < 0) return '0;
    if (raw > 65535) return SMP_MAX;
    return raw[SMP_W-1:0];
  endfunction

  function automatic void clear_chart();
    hist_live     = 1'b0;
    newest_idx    = 0;
    fill          = 0;
    last_store_us = '0;
    top_now       = TOP_MIN;
    shrink_run    = 0;
  endfunction

  function automatic void reset_chart_model();
    for (int unsigned i = 0; i < DEPTH; i++) begin
      hist_level[i]  = '0;
      hist_thresh[i] = '0;
      hist_rate[i]   = '0;
    end
    period_us = PERIOD_RST;
    view_n    = VIEW_RST;
    prev_freq = '0;
    clear_chart();
  endfunction

  // peak over the newest view_n samples, padded by a quarter, then power-of-two top
  function automatic void rescale_top();
    int unsigned peak;
    int unsigned want;
    int unsigned slot;
    peak = 0;
    want = TOP_MIN;
    for (int unsigned back = 0; back < fill && back < view_n; back++) begin
      slot = (newest_idx + DEPTH - back) % DEPTH;
      if (hist_level[slot] > peak) peak = hist_level[slot];
      if (hist_thresh[slot] > peak) peak = hist_thresh[slot];
    end
    peak += peak / 4;
    while (want < peak && want < TOP_MAX) want *= 2;
    if (want > top_now) begin
      top_now    = want;
      shrink_run = 0;
    end else if (want < top_now) begin
      shrink_run++;
      if (shrink_run >= SHRINK_AFTER) begin
        top_now    = want;
        shrink_run = 0;
      end
    end else begin
      shrink_run = 0;
    end
  endfunction

  // advance the mirrored chart by one snapshot and return the readout it yields
  function automatic out_beat_t predict_chart_readout(in_beat_t s);
    out_beat_t   r;
    longint      gap;
    int unsigned kib;
    int unsigned lo;
    int unsigned hi;
    int unsigned base;
    int unsigned top;
    int unsigned pad;
    r = '0;
    gap = longint'({16'h0, s.time_us}) - longint'({16'h0, last_store_us});
    if (!s.streaming || s.tuned_freq != prev_freq ||
        (fill != 0 && gap > 2 * longint'(period_us))) clear_chart();
    prev_freq = s.tuned_freq;

    // store a sample when the period has elapsed or the history is empty
    if (s.streaming) begin
      gap = longint'({16'h0, s.time_us}) - longint'({16'h0, last_store_us});
      if (!(fill != 0 && gap < longint'(period_us))) begin
        kib = s.byte_rate >> KIB_SHIFT;
        last_store_us = s.time_us;
        newest_idx = hist_live ? (newest_idx + 1) % DEPTH : 0;
        hist_live = 1'b1;
        hist_level[newest_idx]  = clamp_raw(s.level_sample);
        hist_thresh[newest_idx] = clamp_raw(s.trigger_level);
        hist_rate[newest_idx]   = (kib > 65535) ? SMP_MAX : SMP_W'(kib);
        if (fill < DEPTH) fill++;
        r.sampled = 1'b1;
        rescale_top();
      end
    end

    // rate chart range over the whole history
    lo = 0;
    hi = 0;
    base = 0;
    if (fill != 0) begin
      lo = 65535;
      for (int unsigned i = 0; i < fill; i++) begin
        if (hist_rate[i] < lo) lo = hist_rate[i];
        if (hist_rate[i] > hi) hi = hist_rate[i];
      end
    end
    if (hi > 0 && lo > hi / 4) begin
      pad  = (hi - lo) / 4 + 1;
      base = (lo >= pad) ? lo - pad : 0;
    end
    top = hi;
    if (top < base + RATE_SPAN) top = base + RATE_SPAN;
    if (top > 65535) top = 65535;

    r.fill_count = FILL_W'(fill);
    r.level_top  = TOP_W'(top_now);
    r.rate_low   = SMP_W'(base);
    r.rate_top   = SMP_W'(top);
    if (hist_live) begin
      r.latest_level     = hist_level[newest_idx];
      r.latest_threshold = hist_thresh[newest_idx];
      r.latest_rate      = hist_rate[newest_idx];
    end
    return r;
  endfunction

  function automatic in_beat_t snap(logic [TIME_W-1:0] t, bit streaming, logic [FREQ_W-1:0] f,
                                    logic signed [RAW_W-1:0] lvl,
                                    logic signed [RAW_W-1:0] trg, logic [RAW_W-1:0] rate);
    in_beat_t s;
    s.time_us       = t;
    s.streaming     = streaming;
    s.tuned_freq    = f;
    s.level_sample  = lvl;
    s.trigger_level = trg;
    s.byte_rate     = rate;
    return s;
  endfunction

  // mostly clean sample sequences with random content, broken up at sequence ends
  function automatic in_beat_t next_traffic_snapshot();
    in_beat_t          s;
    longint unsigned   p;
    longint unsigned   anchor;
    bit                streaming;
    int unsigned       pick;
    p = period_us;
    streaming = 1'b1;
    anchor = (fill != 0) ? longint'({16'h0, last_store_us}) : longint'({16'h0, now_us});
    pick = $urandom_range(0, 99);
    if (seq_left == 0) begin
      seq_left    = $urandom_range(4, 180);
      level_exp   = $urandom_range(0, 17);
      rate_center = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70000)
                                                : $urandom_range(0, 1 << $urandom_range(0, 12));
      rate_spread = $urandom_range(0, 1 << $urandom_range(0, 8));
      case ($urandom_range(0, 3))
        0:       streaming = 1'b0;
        1:       cur_freq = $urandom();
        2:       now_us = anchor + 2 * p + 1 + $urandom_range(0, p);
        default: now_us = now_us - $urandom_range(1, p + 2);
      endcase
    end else begin
      seq_left--;
      if ($urandom_range(0, 199) == 0) streaming = 1'b0;
      if ($urandom_range(0, 199) == 0) cur_freq = $urandom();
      if (pick < 80) now_us = anchor + p + $urandom_range(0, p);
      else if (pick < 90) now_us = anchor + ((p == 0) ? 0 : $urandom_range(0, p - 1));
      else if (pick < 95) now_us = now_us - $urandom_range(1, p + 2);
      // else time stays put
    end
    if ($urandom_range(0, 11) == 0) level_exp = $urandom_range(0, 17);
    s.time_us       = now_us;
    s.streaming     = streaming;
    s.tuned_freq    = cur_freq;
    s.level_sample  = ($urandom_range(0, 32) == 0) ? $urandom()
                                                   : $urandom_range(0, (1 << level_exp) - 1);
    s.trigger_level = ($urandom_range(0, 32) == 0) ? $urandom()
                    : $urandom_range(0, (1 << $urandom_range(0, level_exp)) - 1);
    s.byte_rate     = ($urandom_range(0, 24) == 0) ? $urandom()
                    : (rate_center + $urandom_range(0, rate_spread)) * 1024 +
                      $urandom_range(0, 1023);
    return s;
  endfunction

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // drive one snapshot beat and record its readout once accepted
  task automatic send_snapshot(input in_beat_t s);
    if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i       <= s;
    do @(posedge clk_i); while (in_stall_o);
    pending_readouts.push_back(predict_chart_readout(s));
  endtask

  task automatic drain_readouts();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [PERIOD_W-1:0] value);
    drain_readouts();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SAMPLE_PERIOD) period_us = value;
    else view_n = value[VIEW_W-1:0];
  endtask

  task automatic configure(input int unsigned period, input int unsigned view);
    write_reg(REG_SAMPLE_PERIOD, PERIOD_W'(period));
    write_reg(REG_VIEW_WIDTH, PERIOD_W'(view));
  endtask

  task automatic run_traffic(input int unsigned count);
    now_us   = {16'($urandom()), 32'($urandom())};
    cur_freq = ($urandom_range(0, 1) == 0) ? prev_freq : $urandom();
    seq_left = 0;
    repeat (count) send_snapshot(next_traffic_snapshot());
  endtask

  // reset settings: sampling window, clamps, saturation, clearing causes
  task automatic test_snapshot_edges();
    longint unsigned p;
    p = PERIOD_RST;
    send_snapshot(snap(0, 1, 0, 0, 0, 0));
    send_snapshot(snap(100, 1, 0, 500, 200, 1023));
    send_snapshot(snap(p, 1, 0, 65535, -1, 32'hFFFF_FFFF));
    send_snapshot(snap(2 * p, 1, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1024));
    // time going backwards
    send_snapshot(snap(2 * p - 1000, 1, 0, 10, 10, 0));
    send_snapshot(snap(3 * p, 1, 0, 100, 40000, 32'd67108864));
    // just over twice the period clears, exactly twice does not
    send_snapshot(snap(5 * p + 1, 1, 0, 1, 2, 100 * 1024));
    send_snapshot(snap(7 * p + 1, 1, 0, 3, 3, 100 * 1024));
    send_snapshot(snap(8 * p + 1, 1, 0, 3, 3, 90 * 1024));
    send_snapshot(snap(9 * p, 1, 0, 3, 3, 95 * 1024));
    // frequency change, then streaming stopped
    send_snapshot(snap(9 * p + 1, 1, 32'hFFFF_FFFF, 70000, 65536, 5000));
    send_snapshot(snap(10 * p, 0, 32'hFFFF_FFFF, 50, 50, 2048));
    send_snapshot(snap(48'hFFFF_FFFF_FFFF, 1, 0, 65536, 65535, 1023));
    send_snapshot(snap(0, 1, 0, 7, 7, 2048));
    send_snapshot(snap(48'h8000_0000_0000, 1, 32'h5555_AAAA, -5, 32'h0001_0000, 32'h8000_0000));
  endtask

  // zero period stores every non-negative gap, zero view leaves the top at minimum
  task automatic test_zero_period_and_view();
    configure(0, 0);
    send_snapshot(snap(5000, 1, 7, 300, 100, 4096));
    send_snapshot(snap(5000, 1, 7, 900, 100, 8192));
    send_snapshot(snap(5005, 1, 7, 20, 20, 4096));
    send_snapshot(snap(5002, 1, 7, 20, 20, 4096));
    send_snapshot(snap(5002, 1, 7, 40000, 1, 0));
  endtask

  task automatic test_extreme_registers();
    longint unsigned t;
    configure(24'hFF_FFFF, DEPTH);
    t = 1_000_000;
    send_snapshot(snap(t, 1, 9, 1000, 60000, 30000 * 1024));
    t += 24'hFF_FFFF;
    send_snapshot(snap(t, 1, 9, 2000, 10, 31000 * 1024));
    t += 2 * 64'h00FF_FFFF;
    send_snapshot(snap(t, 1, 9, 3000, 10, 29000 * 1024));
    t += 2 * 64'h00FF_FFFF + 1;
    send_snapshot(snap(t, 1, 9, 4000, 10, 28000 * 1024));
    configure(24'hFF_FFFF, 0);
    run_traffic(100);
  endtask

  // narrow views so the scale both grows and shrinks
  task automatic test_scale_tracking();
    configure(50, 8);
    run_traffic(250);
    configure(0, 1);
    run_traffic(150);
  endtask

  // long clean runs that fill and wrap the history
  task automatic test_long_history();
    configure(1000, DEPTH);
    run_traffic(330);
    configure(PERIOD_RST, VIEW_RST);
    run_traffic(200);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      configure($urandom_range(1, 5000), $urandom_range(1, DEPTH));
      run_traffic(100);
    end
  endtask

  // closing stretch with neither side idling
  task automatic test_back_to_back();
    idle_on = 1'b0;
    configure(200, 32);
    run_traffic(200);
  endtask

  initial begin
    reset_chart_model();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_snapshot_edges();
    test_zero_period_and_view();
    test_extreme_registers();
    test_scale_tracking();
    test_long_history();
    test_random_settings();
    test_back_to_back();
    drain_readouts();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_readouts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side stall: short bursts between free stretches of varying length
  always @(negedge clk_i) begin
    if (!idle_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (free_left != 0) begin
      free_left--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      free_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 700) : $urandom_range(0, 30);
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string field, input logic [TOP_W-1:0] want,
                             input logic [TOP_W-1:0] got);
    if (got !== want) begin
      if (mismatch_cnt < 10) begin
        $display("readout %0d: %s expected %0d, got %0d", readout_no, field, want, got);
      end
      mismatch_cnt++;
    end
  endtask

  // compare each accepted result beat with the oldest expected readout
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readouts.size() == 0) begin
        if (mismatch_cnt < 10) $display("readout %0d: result beat with none expected: %p",
                                        readout_no, out_o);
        mismatch_cnt++;
      end else begin
        want_readout = pending_readouts.pop_front();
        check_field("sampled", want_readout.sampled, out_o.sampled);
        check_field("fill_count", want_readout.fill_count, out_o.fill_count);
        check_field("level_top", want_readout.level_top, out_o.level_top);
        check_field("rate_low", want_readout.rate_low, out_o.rate_low);
        check_field("rate_top", want_readout.rate_top, out_o.rate_top);
        check_field("latest_level", want_readout.latest_level, out_o.latest_level);
        check_field("latest_threshold", want_readout.latest_threshold,
                    out_o.latest_threshold);
        check_field("latest_rate", want_readout.latest_rate, out_o.latest_rate);
      end
      readout_no++;
    end
  end

endmodule
